FILE: hdl/gccs_pkg.sv
// shared types, codes, constants and lookup functions of the grow chamber climate sequencer
`default_nettype none

package gccs_pkg;

	// item kinds carried on the input tuser
	localparam logic [1:0] CMD_TICK   = 2'd0;
	localparam logic [1:0] CMD_SAMPLE = 2'd1;
	localparam logic [1:0] CMD_REFILL = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_TICKS_PER_MINUTE    = 2'd0;
	localparam logic [1:0] CFG_MINUTES_PER_QUARTER = 2'd1;
	localparam logic [1:0] CFG_QUARTERS_PER_PERIOD = 2'd2;
	localparam logic [1:0] CFG_NIGHT_PUMP_EVERY    = 2'd3;

	// configuration reset values
	localparam logic [7:0] TICKS_PER_MINUTE_RST    = 8'd120;
	localparam logic [5:0] MINUTES_PER_QUARTER_RST = 6'd15;
	localparam logic [7:0] QUARTERS_PER_PERIOD_RST = 8'd48;
	localparam logic [7:0] NIGHT_PUMP_EVERY_RST    = 8'd7;

	// ventilation burst minutes
	localparam logic [5:0] VENT_START_MINUTE = 6'd9;
	localparam logic [5:0] VENT_END_MINUTE   = 6'd11;

	// temperature bands in degrees
	localparam logic [5:0] T_FULL_MAX = 6'd18;
	localparam logic [5:0] T_70_MAX   = 6'd22;
	localparam logic [5:0] T_50_MAX   = 6'd28;
	localparam logic [5:0] T_30_MAX   = 6'd30;
	localparam logic [5:0] T_FAN_LOW  = 6'd35;
	localparam logic [5:0] T_FAN_MID  = 6'd40;
	localparam logic [5:0] T_FAN_HIGH = 6'd45;
	localparam logic [7:0] HUMID_DRY  = 8'd70;

	// sensor conversion constants
	localparam logic [10:0] ADC_FULL       = 11'd1023;
	localparam logic [11:0] DIV10_RECIP    = 12'd3277;  // 2^15 / 10, rounded up
	localparam logic [17:0] HUMID_OFFSET   = 18'd26400;
	localparam logic [11:0] HUMID_ROUND    = 12'd4;
	localparam logic [9:0]  HUMID_ZERO_MAX = 10'd163;   // readings up to here give zero percent

	typedef enum logic [2:0] {
		HEAT_NONE = 3'd0,
		HEAT_FULL = 3'd1,
		HEAT_70   = 3'd2,
		HEAT_50   = 3'd3,
		HEAT_30   = 3'd4
	} heat_level_t;

	// input tdata, last field in the lowest bits
	typedef struct packed {
		logic [2:0] pad;
		logic       stop_button;
		logic [9:0] humid_raw;
		logic [9:0] temp_raw;
	} in_item_t;

	// output tdata, last field in the lowest bits
	typedef struct packed {
		logic       pad;
		logic [7:0] humidity_pct;
		logic [5:0] temperature_c;
		logic [1:0] phase;
		logic       swap_due;
		logic       quarter_led;
		logic [9:0] fan_compare;
		logic [6:0] heater_pot_steps;
		logic       heater_on;
		logic       oxygenator_on;
		logic       pump_on;
		logic       light_on;
	} result_t;

	// converted sensor readings
	typedef struct packed {
		logic [5:0] temp_c;
		logic [7:0] humid_pct;
	} sensor_t;

	function automatic logic [6:0] pot_steps(input heat_level_t lvl);
		logic [6:0] s;
		unique case (lvl)
			HEAT_70: s = 7'd42;
			HEAT_50: s = 7'd70;
			HEAT_30: s = 7'd98;
			default: s = 7'd0;
		endcase
		return s;
	endfunction

	function automatic logic [9:0] fan_compare(input logic [1:0] lvl);
		logic [9:0] c;
		unique case (lvl)
			2'd0: c = 10'd0;
			2'd1: c = 10'd199;
			2'd2: c = 10'd399;
			2'd3: c = 10'd799;
			default: c = 10'd0;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/gccs_sensor_conv.sv
// raw converter readings to whole degrees and whole percent humidity
`default_nettype none

module gccs_sensor_conv (
	input  wire logic [9:0]       temp_raw,
	input  wire logic [9:0]       humid_raw,
	output gccs_pkg::sensor_t     sens
);

	logic [15:0] temp_x;
	logic [5:0]  temp_q0;
	logic [10:0] temp_r;
	logic [5:0]  temp_c;

	logic [11:0] hum_x;
	logic [23:0] hum_prod;
	logic [8:0]  hum_p;
	logic [17:0] hum_161;
	logic [17:0] hum_d;
	logic [7:0]  hum_q0;
	logic [10:0] hum_r;
	logic [7:0]  hum_q;

	// temperature: raw * 50 / 1023, x / 1023 = (x >> 10) plus one correction step
	assign temp_x  = {1'b0, temp_raw, 5'd0} + {2'd0, temp_raw, 4'd0} + {5'd0, temp_raw, 1'b0};
	assign temp_q0 = temp_x[15:10];
	assign temp_r  = {1'b0, temp_x[9:0]} + {5'd0, temp_q0};
	assign temp_c  = temp_q0 + {5'd0, (temp_r >= gccs_pkg::ADC_FULL)};

	// humidity: (161300 h - 26399538) / 1023000, split as /1000 then /1023
	// numerator / 1000 = 161 h - 26400 + floor((3 h + 4) / 10)
	assign hum_x    = {2'd0, humid_raw} + {1'b0, humid_raw, 1'b0} + gccs_pkg::HUMID_ROUND;
	assign hum_prod = hum_x * gccs_pkg::DIV10_RECIP;
	assign hum_p    = hum_prod[23:15];
	assign hum_161  = {1'b0, humid_raw, 7'd0} + {3'd0, humid_raw, 5'd0} + {8'd0, humid_raw};
	assign hum_d    = hum_161 + {9'd0, hum_p} - gccs_pkg::HUMID_OFFSET;
	assign hum_q0   = hum_d[17:10];
	assign hum_r    = {1'b0, hum_d[9:0]} + {3'd0, hum_q0};
	assign hum_q    = hum_q0 + {7'd0, (hum_r >= gccs_pkg::ADC_FULL)};

	// saturate at zero below the offset
	assign sens.temp_c    = temp_c;
	assign sens.humid_pct = (humid_raw <= gccs_pkg::HUMID_ZERO_MAX) ? 8'd0 : hum_q;

endmodule

`default_nettype wire

FILE: hdl/grow_chamber_climate_sequencer_unit.sv
// top level of the grow chamber climate sequencer
`default_nettype none

// The block takes one item per clock cycle: a half-second tick, a sensor sample or a refill
// acknowledgement (kind on s_axis_tuser). Every accepted item produces exactly one result,
// presented on the master side in the cycle after the transfer. The whole update of the counter
// cascade, sensor conversion and control pass is one short combinational step between the state
// registers and the result register, so the sustained rate is one item per cycle; the input side
// stalls only while a result sits in the output register and m_axis_tready is low. Configuration
// writes are always taken (cfg_ready is tied high) and should be made while the block is idle.
// There is no clearing pass after reset.
module grow_chamber_climate_sequencer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,   // temp_raw, humid_raw, stop_button, zero pad
	input  wire logic [1:0]  s_axis_tuser,   // command
	// result stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,   // light_on, pump_on, oxygenator_on, heater_on,
	                                         // heater_pot_steps, fan_compare, quarter_led,
	                                         // swap_due, phase, temperature_c, humidity_pct, pad
	// configuration writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);

	gccs_pkg::in_item_t  item;
	gccs_pkg::sensor_t   sens;
	gccs_pkg::result_t   res_d;
	gccs_pkg::result_t   res_q;
	logic                accept;
	logic                out_valid_q;

	// configuration registers
	logic [7:0] ticks_per_minute_q;
	logic [5:0] minutes_per_quarter_q;
	logic [7:0] quarters_per_period_q;
	logic [7:0] night_pump_every_q;

	// sequencer state
	logic [7:0]            tick_count_q,    tick_count_d;
	logic [5:0]            minute_count_q,  minute_count_d;
	logic [7:0]            quarter_count_q, quarter_count_d;
	logic [7:0]            quarter_seen_q,  quarter_seen_d;
	logic [1:0]            phase_count_q,   phase_count_d;
	logic [1:0]            swap_count_q,    swap_count_d;
	logic                  swap_flag_q,     swap_flag_d;
	logic [7:0]            night_count_q,   night_count_d;
	logic                  pump_state_q,    pump_state_d;
	logic                  oxy_state_q,     oxy_state_d;
	logic                  led_state_q,     led_state_d;
	gccs_pkg::heat_level_t heater_level_q,  heater_level_d;
	logic [1:0]            fan_level_q,     fan_level_d;
	logic [5:0]            temp_value_q,    temp_value_d;
	logic [7:0]            humid_value_q,   humid_value_d;

	assign item = gccs_pkg::in_item_t'(s_axis_tdata);

	// handshakes
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	gccs_sensor_conv u_conv (
		.temp_raw  (item.temp_raw),
		.humid_raw (item.humid_raw),
		.sens      (sens)
	);

	// next state for one item: command update, then stop override or control pass
	always_comb begin
		tick_count_d    = tick_count_q;
		minute_count_d  = minute_count_q;
		quarter_count_d = quarter_count_q;
		quarter_seen_d  = quarter_seen_q;
		phase_count_d   = phase_count_q;
		swap_count_d    = swap_count_q;
		swap_flag_d     = swap_flag_q;
		night_count_d   = night_count_q;
		pump_state_d    = pump_state_q;
		oxy_state_d     = oxy_state_q;
		led_state_d     = led_state_q;
		heater_level_d  = heater_level_q;
		fan_level_d     = fan_level_q;
		temp_value_d    = temp_value_q;
		humid_value_d   = humid_value_q;

		unique case (s_axis_tuser)
			gccs_pkg::CMD_TICK: begin
				// counter cascade
				tick_count_d = tick_count_d + 8'd1;
				if (tick_count_d >= ticks_per_minute_q) begin
					tick_count_d   = 8'd0;
					minute_count_d = minute_count_d + 6'd1;
				end
				if (minute_count_d >= minutes_per_quarter_q) begin
					minute_count_d  = 6'd0;
					quarter_count_d = quarter_count_d + 8'd1;
					led_state_d     = !led_state_d;
				end
				// ventilation burst
				if (minute_count_d == gccs_pkg::VENT_START_MINUTE)
					fan_level_d = 2'd1;
				if (minute_count_d == gccs_pkg::VENT_END_MINUTE)
					fan_level_d = 2'd0;
				// phase change
				if (quarter_count_d >= quarters_per_period_q) begin
					quarter_count_d = 8'd0;
					phase_count_d   = phase_count_d + 2'd1;
					heater_level_d  = gccs_pkg::HEAT_NONE;
					swap_count_d    = swap_count_d + 2'd1;
					if (swap_count_d == 2'd0)
						swap_flag_d = 1'b1;
				end
			end
			gccs_pkg::CMD_SAMPLE: begin
				temp_value_d  = sens.temp_c;
				humid_value_d = sens.humid_pct;
			end
			gccs_pkg::CMD_REFILL: begin
				swap_count_d = 2'd0;
				swap_flag_d  = 1'b0;
			end
			default: begin
			end
		endcase

		if (item.stop_button) begin
			heater_level_d = gccs_pkg::HEAT_NONE;
			fan_level_d    = 2'd0;
			pump_state_d   = 1'b0;
		end else if (!phase_count_d[0]) begin
			// day: heater band
			if (temp_value_d <= gccs_pkg::T_FULL_MAX)
				heater_level_d = gccs_pkg::HEAT_FULL;
			else if (temp_value_d <= gccs_pkg::T_70_MAX)
				heater_level_d = gccs_pkg::HEAT_70;
			else if (temp_value_d <= gccs_pkg::T_50_MAX)
				heater_level_d = gccs_pkg::HEAT_50;
			else if (temp_value_d <= gccs_pkg::T_30_MAX)
				heater_level_d = gccs_pkg::HEAT_30;
			else
				heater_level_d = gccs_pkg::HEAT_NONE;
			// day: fan band, exactly 35 degrees leaves the fan alone
			if (temp_value_d > gccs_pkg::T_FAN_LOW && temp_value_d <= gccs_pkg::T_FAN_MID)
				fan_level_d = 2'd1;
			else if (temp_value_d > gccs_pkg::T_FAN_MID && temp_value_d < gccs_pkg::T_FAN_HIGH)
				fan_level_d = 2'd2;
			else if (temp_value_d >= gccs_pkg::T_FAN_HIGH)
				fan_level_d = 2'd3;
			if (temp_value_d < gccs_pkg::T_FAN_LOW && humid_value_d < gccs_pkg::HUMID_DRY &&
			    (minute_count_d > gccs_pkg::VENT_END_MINUTE ||
			     minute_count_d < gccs_pkg::VENT_START_MINUTE))
				fan_level_d = 2'd0;
			// day: pump and oxygenator alternate each new quarter
			if (quarter_count_d != quarter_seen_d) begin
				pump_state_d   = !pump_state_d;
				oxy_state_d    = !pump_state_d;
				quarter_seen_d = quarter_count_d;
			end
		end else if (quarter_count_d != quarter_seen_d) begin
			// night pattern
			pump_state_d  = 1'b0;
			oxy_state_d   = !oxy_state_d;
			night_count_d = night_count_d + 8'd1;
			if (night_count_d >= night_pump_every_q) begin
				night_count_d = 8'd0;
				pump_state_d  = 1'b1;
			end
			quarter_seen_d = quarter_count_d;
		end
	end

	// result fields from the updated state
	always_comb begin
		res_d                  = '0;
		res_d.light_on         = !item.stop_button && !phase_count_d[0];
		res_d.pump_on          = pump_state_d;
		res_d.oxygenator_on    = oxy_state_d;
		res_d.heater_on        = (heater_level_d != gccs_pkg::HEAT_NONE);
		res_d.heater_pot_steps = gccs_pkg::pot_steps(heater_level_d);
		res_d.fan_compare      = gccs_pkg::fan_compare(fan_level_d);
		res_d.quarter_led      = led_state_d;
		res_d.swap_due         = swap_flag_d;
		res_d.phase            = phase_count_d;
		res_d.temperature_c    = temp_value_d;
		res_d.humidity_pct     = humid_value_d;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_per_minute_q    <= gccs_pkg::TICKS_PER_MINUTE_RST;
			minutes_per_quarter_q <= gccs_pkg::MINUTES_PER_QUARTER_RST;
			quarters_per_period_q <= gccs_pkg::QUARTERS_PER_PERIOD_RST;
			night_pump_every_q    <= gccs_pkg::NIGHT_PUMP_EVERY_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				gccs_pkg::CFG_TICKS_PER_MINUTE:    ticks_per_minute_q    <= cfg_data;
				gccs_pkg::CFG_MINUTES_PER_QUARTER: minutes_per_quarter_q <= cfg_data[5:0];
				gccs_pkg::CFG_QUARTERS_PER_PERIOD: quarters_per_period_q <= cfg_data;
				gccs_pkg::CFG_NIGHT_PUMP_EVERY:    night_pump_every_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer state, updated on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q    <= 8'd0;
			minute_count_q  <= 6'd0;
			quarter_count_q <= 8'd0;
			quarter_seen_q  <= 8'd0;
			phase_count_q   <= 2'd0;
			swap_count_q    <= 2'd0;
			swap_flag_q     <= 1'b0;
			night_count_q   <= 8'd0;
			pump_state_q    <= 1'b1;
			oxy_state_q     <= 1'b0;
			led_state_q     <= 1'b0;
			heater_level_q  <= gccs_pkg::HEAT_NONE;
			fan_level_q     <= 2'd0;
			temp_value_q    <= 6'd0;
			humid_value_q   <= 8'd0;
		end else if (accept) begin
			tick_count_q    <= tick_count_d;
			minute_count_q  <= minute_count_d;
			quarter_count_q <= quarter_count_d;
			quarter_seen_q  <= quarter_seen_d;
			phase_count_q   <= phase_count_d;
			swap_count_q    <= swap_count_d;
			swap_flag_q     <= swap_flag_d;
			night_count_q   <= night_count_d;
			pump_state_q    <= pump_state_d;
			oxy_state_q     <= oxy_state_d;
			led_state_q     <= led_state_d;
			heater_level_q  <= heater_level_d;
			fan_level_q     <= fan_level_d;
			temp_value_q    <= temp_value_d;
			humid_value_q   <= humid_value_d;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = res_q;

endmodule

`default_nettype wire

FILE: hdl/gccs_checker.sv
// port-level checks of the grow chamber climate sequencer, bound to the top level
`default_nettype none

module gccs_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [39:0] m_axis_tdata
);

	gccs_pkg::result_t res;

	assign res = gccs_pkg::result_t'(m_axis_tdata);

	// a held result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// every input transfer shows a result next cycle
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
		else $error("input transfer without result");

	// heater off means no pot steps
	a_heat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !res.heater_on |-> res.heater_pot_steps == 7'd0)
		else $error("pot steps set with heater off");

	// fan compare is one of the four duties
	a_fan: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (res.fan_compare == 10'd0 || res.fan_compare == 10'd199 ||
		                   res.fan_compare == 10'd399 || res.fan_compare == 10'd799))
		else $error("fan compare out of set");

	// lighting only in day phases
	a_light: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.light_on |-> !res.phase[0])
		else $error("light on at night");

endmodule

bind grow_chamber_climate_sequencer_unit gccs_checker u_gccs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
